@@ sv/sct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite corner transform package
// Shared constants, arctangent table and CORDIC lane type.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int TRIG_STAGES_DEF = 16;
    localparam int STAGE_CAP       = 32;

    // Gain-corrected start value and pi in Q30.
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [31:0]        PI_Q30   = 32'hC90FDAA2;

    // One word in flight through the CORDIC rotator.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic [1:0]         quad;
    } cordic_t;

    // Arctangent of 2^-i in Q30, entry 0 is pi/4.
    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] r;
        begin
            case (i)
                0:  r = 34'sd843314857;
                1:  r = 34'sd497837829;
                2:  r = 34'sd263043837;
                3:  r = 34'sd133525159;
                4:  r = 34'sd67021687;
                5:  r = 34'sd33543516;
                6:  r = 34'sd16775851;
                7:  r = 34'sd8388437;
                8:  r = 34'sd4194283;
                9:  r = 34'sd2097149;
                10: r = 34'sd1048576;
                11: r = 34'sd524288;
                12: r = 34'sd262144;
                13: r = 34'sd131072;
                14: r = 34'sd65536;
                15: r = 34'sd32768;
                16: r = 34'sd16384;
                17: r = 34'sd8192;
                18: r = 34'sd4096;
                19: r = 34'sd2048;
                20: r = 34'sd1024;
                21: r = 34'sd512;
                22: r = 34'sd256;
                23: r = 34'sd128;
                24: r = 34'sd64;
                25: r = 34'sd32;
                26: r = 34'sd16;
                27: r = 34'sd8;
                28: r = 34'sd4;
                29: r = 34'sd2;
                30: r = 34'sd1;
                31: r = 34'sd1;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ sv/sprite_corner_transform_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite corner transform top level
// Scale, rotate and translate the four corners of a sprite rectangle.
// ----------------------------------------------------------------------------
// Input channel: one sprite word per in_valid/in_stall handshake.
// Output channel: four corner words per sprite, in order top-left,
// top-right, bottom-right, bottom-left; last_corner marks the fourth.
// The block takes a new sprite while earlier ones are still in the pipe;
// after each accept, an input pace counter holds in_stall high so that
// no sprite reaches the corner sequencer before the previous one has
// issued its fourth corner; each corner then flows one per cycle through
// the remaining stages while the output is not stalled. The first corner
// passes two angle stages, the CORDIC stages, and the quadrant, sequencer,
// scale, multiply and sum stages before the output register.
// The whole pipe advances together; when out_stall is high and the output
// register is full, every stage holds and nothing is lost or repeated.
// Reset clears all valid bits and the sequencer; payload is not reset.
// ----------------------------------------------------------------------------
module sprite_corner_transform_top #(
    parameter int TRIG_STAGES = sct_pkg::TRIG_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        rect_width,
    input  logic [15:0]        rect_height,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [15:0] scale_x,
    input  logic signed [15:0] scale_y,
    input  logic [15:0]        angle,
    input  logic signed [31:0] position_x,
    input  logic signed [31:0] position_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] corner_x,
    output logic signed [31:0] corner_y,
    output logic [1:0]         corner_index,
    output logic               last_corner
);
    import sct_pkg::*;

    localparam int N = (TRIG_STAGES < STAGE_CAP) ? TRIG_STAGES : STAGE_CAP;

    typedef struct packed {
        logic [15:0]        w;
        logic [15:0]        h;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [15:0] kx;
        logic signed [15:0] ky;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } sprite_t;

    logic en;
    assign en = !(out_valid && out_stall);

    // Angle stage 1: quadrant and residual magnitude product.
    // Angles near a full turn wrap to quadrant zero and keep a residual
    // of up to 16 bits.
    logic               a1_valid_reg;
    sprite_t            a1_spr_reg;
    logic [1:0]         a1_q_reg;
    logic               a1_neg_reg;
    logic [47:0]        a1_prod_reg;
    logic [1:0]         q_next;
    logic signed [16:0] a_next;
    logic [15:0]        mag_next;

    always_comb
    begin
        q_next   = 2'(({1'b0, angle} + 17'd8192) >> 14);
        a_next   = $signed({1'b0, angle}) - $signed({1'b0, q_next, 14'd0});
        mag_next = a_next[16] ? 16'(-a_next) : 16'(a_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a1_valid_reg <= 1'b0;
        else if (en)
            a1_valid_reg <= in_valid && !in_stall;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_spr_reg  <= '{rect_width, rect_height, origin_x, origin_y,
                             scale_x, scale_y, position_x, position_y};
            a1_q_reg    <= q_next;
            a1_neg_reg  <= a_next[16];
            a1_prod_reg <= {32'd0, mag_next} * {16'd0, PI_Q30};
        end
    end

    // Angle stage 2: round to Q30 and apply sign.
    logic    a2_valid_reg;
    cordic_t a2_word_reg;
    sprite_t a2_spr_reg;
    logic signed [33:0] z_mag;

    assign z_mag = $signed({1'b0, 33'((a1_prod_reg + 48'd16384) >> 15)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a2_valid_reg <= 1'b0;
        else if (en)
            a2_valid_reg <= a1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_word_reg.x    <= GAIN_Q30;
            a2_word_reg.y    <= '0;
            a2_word_reg.z    <= a1_neg_reg ? -z_mag : z_mag;
            a2_word_reg.quad <= a1_q_reg;
            a2_spr_reg       <= a1_spr_reg;
        end
    end

    // CORDIC rotator, with the sprite fields delayed alongside.
    logic    cr_valid;
    cordic_t cr_word;
    sprite_t spr_dly_reg [N];

    sct_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (a2_valid_reg),
        .in_word  (a2_word_reg),
        .out_valid(cr_valid),
        .out_word (cr_word)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spr_dly_reg[0] <= a2_spr_reg;
            for (int i = 1; i < N; i++)
                spr_dly_reg[i] <= spr_dly_reg[i-1];
        end
    end

    // Quadrant stage: rotate by quarter turns and round to Q20.
    logic               qd_valid_reg;
    sprite_t            qd_spr_reg;
    logic signed [21:0] c_reg;
    logic signed [21:0] s_reg;
    logic signed [33:0] c_pre;
    logic signed [33:0] s_pre;

    always_comb
    begin
        case (cr_word.quad)
            2'd0:    begin c_pre = cr_word.x;  s_pre = cr_word.y;  end
            2'd1:    begin c_pre = -cr_word.y; s_pre = cr_word.x;  end
            2'd2:    begin c_pre = -cr_word.x; s_pre = -cr_word.y; end
            default: begin c_pre = cr_word.y;  s_pre = -cr_word.x; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qd_valid_reg <= 1'b0;
        else if (en)
            qd_valid_reg <= cr_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg      <= 22'((c_pre + 34'sd512) >>> 10);
            s_reg      <= 22'((s_pre + 34'sd512) >>> 10);
            qd_spr_reg <= spr_dly_reg[N-1];
        end
    end

    // Corner sequencer: holds one sprite and walks its four corners.
    logic [1:0]         k_reg;
    logic               busy_reg;
    sprite_t            sq_spr_reg;
    logic signed [21:0] sq_c_reg;
    logic signed [21:0] sq_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= 2'd0;
            busy_reg <= 1'b0;
        end
        else if (en)
        begin
            if (busy_reg)
            begin
                k_reg    <= k_reg + 2'd1;
                busy_reg <= (k_reg != 2'd3) || qd_valid_reg;
            end
            else if (qd_valid_reg)
            begin
                k_reg    <= 2'd0;
                busy_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && qd_valid_reg && (!busy_reg || k_reg == 2'd3))
        begin
            sq_spr_reg <= qd_spr_reg;
            sq_c_reg   <= c_reg;
            sq_s_reg   <= s_reg;
        end
    end

    // Sprite accept is paced so that a new sprite never reaches the
    // sequencer before the previous one has issued its fourth corner.
    logic [1:0] pace_reg;
    assign in_stall = !en || (pace_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pace_reg <= 2'd0;
        else if (en)
        begin
            if (in_valid && !in_stall)
                pace_reg <= 2'd3;
            else if (pace_reg != 2'd0)
                pace_reg <= pace_reg - 2'd1;
        end
    end

    // Scale stage: local corner minus origin, times scale, rounded.
    logic               sc_valid_reg;
    logic [1:0]         sc_k_reg;
    logic signed [41:0] sx_reg;
    logic signed [41:0] sy_reg;
    logic signed [21:0] sc_c_reg;
    logic signed [21:0] sc_s_reg;
    logic signed [31:0] sc_px_reg;
    logic signed [31:0] sc_py_reg;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [49:0] mx;
    logic signed [49:0] my;

    always_comb
    begin
        dx = ((k_reg == 2'd1) || (k_reg == 2'd2))
             ? $signed({2'b0, sq_spr_reg.w, 16'd0}) : 34'sd0;
        dy = k_reg[1] ? $signed({2'b0, sq_spr_reg.h, 16'd0}) : 34'sd0;
        dx = dx - 34'(sq_spr_reg.ox);
        dy = dy - 34'(sq_spr_reg.oy);
        mx = 50'(dx) * 50'(sq_spr_reg.kx) + 50'sd128;
        my = 50'(dy) * 50'(sq_spr_reg.ky) + 50'sd128;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_valid_reg <= 1'b0;
        else if (en)
            sc_valid_reg <= busy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_k_reg  <= k_reg;
            sx_reg    <= 42'(mx >>> 8);
            sy_reg    <= 42'(my >>> 8);
            sc_c_reg  <= sq_c_reg;
            sc_s_reg  <= sq_s_reg;
            sc_px_reg <= sq_spr_reg.px;
            sc_py_reg <= sq_spr_reg.py;
        end
    end

    // Multiply stage: the four rotation products.
    logic               mu_valid_reg;
    logic [1:0]         mu_k_reg;
    logic signed [63:0] p_xc_reg;
    logic signed [63:0] p_ys_reg;
    logic signed [63:0] p_xs_reg;
    logic signed [63:0] p_yc_reg;
    logic signed [31:0] mu_px_reg;
    logic signed [31:0] mu_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mu_valid_reg <= 1'b0;
        else if (en)
            mu_valid_reg <= sc_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mu_k_reg  <= sc_k_reg;
            p_xc_reg  <= 64'(sx_reg) * 64'(sc_c_reg);
            p_ys_reg  <= 64'(sy_reg) * 64'(sc_s_reg);
            p_xs_reg  <= 64'(sx_reg) * 64'(sc_s_reg);
            p_yc_reg  <= 64'(sy_reg) * 64'(sc_c_reg);
            mu_px_reg <= sc_px_reg;
            mu_py_reg <= sc_py_reg;
        end
    end

    // Sum stage: combine, round to Q16.16.
    logic               su_valid_reg;
    logic [1:0]         su_k_reg;
    logic signed [44:0] rx_reg;
    logic signed [44:0] ry_reg;
    logic signed [31:0] su_px_reg;
    logic signed [31:0] su_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            su_valid_reg <= 1'b0;
        else if (en)
            su_valid_reg <= mu_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            su_k_reg  <= mu_k_reg;
            rx_reg    <= 45'((p_xc_reg - p_ys_reg + 64'sd524288) >>> 20);
            ry_reg    <= 45'((p_xs_reg + p_yc_reg + 64'sd524288) >>> 20);
            su_px_reg <= mu_px_reg;
            su_py_reg <= mu_py_reg;
        end
    end

    // Output stage: translate and saturate.
    logic signed [45:0] tx;
    logic signed [45:0] ty;
    logic               out_valid_reg;

    assign tx = 46'(rx_reg) + 46'(su_px_reg);
    assign ty = 46'(ry_reg) + 46'(su_py_reg);

    function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
        logic signed [31:0] r;
        begin
            if (v > 46'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -46'sd2147483648)
                r = 32'sh80000000;
            else
                r = 32'(v);
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= su_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            corner_x     <= sat32(tx);
            corner_y     <= sat32(ty);
            corner_index <= su_k_reg;
            last_corner  <= (su_k_reg == 2'd3);
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // A stalled output holds its word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(corner_x) && $stable(corner_index))
        else $error("output word changed under stall");

    // Corner index advances by one between issued corners of a sprite.
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        en && busy_reg && k_reg != 2'd3 |=> busy_reg && k_reg == $past(k_reg) + 2'd1)
        else $error("corner sequence broken");

    // A new sprite reaches the sequencer only when it is free.
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        en && qd_valid_reg |-> !busy_reg || k_reg == 2'd3)
        else $error("sprite overran the corner sequencer");
`endif

endmodule

@@ sv/sct_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite corner transform CORDIC rotator
// One register stage per iteration; words advance when the pipe is enabled.
// ----------------------------------------------------------------------------
module sct_cordic #(
    parameter int TRIG_STAGES = sct_pkg::TRIG_STAGES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  sct_pkg::cordic_t in_word,
    output logic             out_valid,
    output sct_pkg::cordic_t out_word
);
    import sct_pkg::*;

    localparam int N = (TRIG_STAGES < STAGE_CAP) ? TRIG_STAGES : STAGE_CAP;

    cordic_t      word_reg  [N];
    cordic_t      word_next [N];
    logic [N-1:0] valid_reg;

    // One micro-rotation per stage, each fed by the register of the stage before.
    always_comb
    begin
        cordic_t w_in;
        for (int i = 0; i < N; i++)
        begin
            if (i == 0)
                w_in = in_word;
            else
                w_in = word_reg[i-1];
            word_next[i] = w_in;
            if (!w_in.z[33])
            begin
                word_next[i].x = w_in.x - (w_in.y >>> i);
                word_next[i].y = w_in.y + (w_in.x >>> i);
                word_next[i].z = w_in.z - atan_q30(i);
            end
            else
            begin
                word_next[i].x = w_in.x + (w_in.y >>> i);
                word_next[i].y = w_in.y - (w_in.x >>> i);
                word_next[i].z = w_in.z + atan_q30(i);
            end
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[N-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
                word_reg[i] <= word_next[i];
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_word  = word_reg[N-1];

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite corner transform testbench
// Sends sprite words through the block and checks each of the four corner
// words against a bit-exact CORDIC and fixed-point predictor kept here,
// with random bursts on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_STAGES = 16;
    localparam int PIPE_DEPTH = NUM_STAGES + 8;

    typedef struct packed {
        logic [15:0]        width;
        logic [15:0]        height;
        logic signed [31:0] org_x;
        logic signed [31:0] org_y;
        logic signed [15:0] scl_x;
        logic signed [15:0] scl_y;
        logic [15:0]        ang;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } sprite_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [1:0]         idx;
        logic               last;
    } corner_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [15:0]        rect_width = '0;
    logic [15:0]        rect_height = '0;
    logic signed [31:0] origin_x = '0;
    logic signed [31:0] origin_y = '0;
    logic signed [15:0] scale_x = '0;
    logic signed [15:0] scale_y = '0;
    logic [15:0]        angle = '0;
    logic signed [31:0] position_x = '0;
    logic signed [31:0] position_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] corner_x;
    logic signed [31:0] corner_y;
    logic [1:0]         corner_index;
    logic               last_corner;

    corner_t expected_corners[$];
    int      mismatch_count = 0;
    int      burst_left = 0;
    int      idle_mode = 0;
    int      stall_mode = 0;
    int      stall_cycle = 0;

    sprite_corner_transform_top #(
        .TRIG_STAGES(NUM_STAGES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rect_width(rect_width),
        .rect_height(rect_height),
        .origin_x(origin_x),
        .origin_y(origin_y),
        .scale_x(scale_x),
        .scale_y(scale_y),
        .angle(angle),
        .position_x(position_x),
        .position_y(position_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .corner_x(corner_x),
        .corner_y(corner_y),
        .corner_index(corner_index),
        .last_corner(last_corner)
    );

    // Clock generation.
    always #1 clk = ~clk;

    // Arctangent of 2^-i in Q30, summed from its power series in Q60.
    function automatic longint arctan_q30(int i);
        longint unsigned p;
        longint unsigned acc;
        longint unsigned term;
        longint unsigned k;
        begin
            if (i == 0)
                return 64'sd843314857;
            acc = 0;
            k = 0;
            p = 64'd1 << (60 - i);
            while (p != 0)
            begin
                term = p / (2 * k + 1);
                if (k[0] == 1'b0)
                    acc = acc + term;
                else
                    acc = acc - term;
                p = p >> (2 * i);
                k++;
            end
            return longint'((acc + (64'd1 << 29)) >> 30);
        end
    endfunction

    // Cosine and sine of the angle in Q20, from the quadrant and a CORDIC.
    function automatic void angle_to_trig(logic [15:0] ang, output longint cos_q20,
                                          output longint sin_q20);
        int unsigned quad;
        longint      resid;
        longint      mag;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        longint      c;
        longint      s;
        begin
            quad = ((int'(ang) + 8192) >> 14) & 3;
            resid = longint'(ang) - 16384 * longint'(quad);
            mag = (resid < 0) ? -resid : resid;
            z = (mag * 64'sd3373259426 + (64'sd1 << 14)) >>> 15;
            if (resid < 0)
                z = -z;
            x = 64'sd652032874;
            y = 0;
            for (int i = 0; i < NUM_STAGES && i < 32; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - arctan_q30(i);
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + arctan_q30(i);
                end
            end
            case (quad)
                0: begin c = x;  s = y;  end
                1: begin c = -y; s = x;  end
                2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
            cos_q20 = (c + 512) >>> 10;
            sin_q20 = (s + 512) >>> 10;
        end
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        begin
            if (v > 64'sd2147483647)
                return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        end
    endfunction

    // Queue the four transformed corners of one accepted sprite.
    task automatic predict_corners(sprite_t sp);
        longint  c;
        longint  s;
        longint  lx;
        longint  ly;
        longint  sx;
        longint  sy;
        longint  rx;
        longint  ry;
        corner_t cr;
        begin
            angle_to_trig(sp.ang, c, s);
            for (int k = 0; k < 4; k++)
            begin
                lx = (k == 1 || k == 2) ? longint'(sp.width) * 65536 : 0;
                ly = (k >= 2) ? longint'(sp.height) * 65536 : 0;
                sx = ((lx - longint'(sp.org_x)) * longint'(sp.scl_x) + 128) >>> 8;
                sy = ((ly - longint'(sp.org_y)) * longint'(sp.scl_y) + 128) >>> 8;
                rx = (sx * c - sy * s + (64'sd1 << 19)) >>> 20;
                ry = (sx * s + sy * c + (64'sd1 << 19)) >>> 20;
                cr.x = clamp32(rx + longint'(sp.pos_x));
                cr.y = clamp32(ry + longint'(sp.pos_y));
                cr.idx = k[1:0];
                cr.last = (k == 3);
                expected_corners.push_back(cr);
            end
        end
    endtask

    // Drive one sprite word, wait for its handshake, then maybe leave a gap.
    task automatic send_sprite(sprite_t sp);
        int gap;
        begin
            in_valid <= 1'b1;
            rect_width <= sp.width;
            rect_height <= sp.height;
            origin_x <= sp.org_x;
            origin_y <= sp.org_y;
            scale_x <= sp.scl_x;
            scale_y <= sp.scl_y;
            angle <= sp.ang;
            position_x <= sp.pos_x;
            position_y <= sp.pos_y;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            predict_corners(sp);
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 12);
                if (idle_mode != 0)
                begin
                    gap = $urandom_range(1, 9);
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // Output stall pattern: phases of no stall, random stall and long stalls.
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 97 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= (stall_cycle % 23) < 15;
        endcase
    end

    // Compare each accepted corner word with the oldest expectation.
    always @(posedge clk)
    begin
        corner_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_corners.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected corner word: x=%0d y=%0d idx=%0d last=%0d",
                             corner_x, corner_y, corner_index, last_corner);
            end
            else
            begin
                want = expected_corners.pop_front();
                if (corner_x !== want.x || corner_y !== want.y ||
                    corner_index !== want.idx || last_corner !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Corner mismatch: expected x=%0d y=%0d idx=%0d last=%0d",
                                 want.x, want.y, want.idx, want.last);
                        $display("                 got      x=%0d y=%0d idx=%0d last=%0d",
                                 corner_x, corner_y, corner_index, last_corner);
                    end
                end
            end
        end
    end

    function automatic sprite_t make_sprite(logic [15:0] w, logic [15:0] h,
                                            logic [31:0] ox, logic [31:0] oy,
                                            logic [15:0] kx, logic [15:0] ky,
                                            logic [15:0] a,
                                            logic [31:0] px, logic [31:0] py);
        sprite_t sp;
        begin
            sp.width = w;
            sp.height = h;
            sp.org_x = ox;
            sp.org_y = oy;
            sp.scl_x = kx;
            sp.scl_y = ky;
            sp.ang = a;
            sp.pos_x = px;
            sp.pos_y = py;
            return sp;
        end
    endfunction

    // Field extremes, cardinal and octant angles, empty rectangles,
    // zero and mirrored scale, and saturation in both directions.
    task automatic test_directed();
        begin
            idle_mode = 0;
            send_sprite(make_sprite(16'd32, 16'd16, 32'h0, 32'h0, 16'h0100, 16'h0100,
                                    16'd0, 32'h0, 32'h0));
            send_sprite(make_sprite(16'd32, 16'd16, 32'h0, 32'h0, 16'h0100, 16'h0100,
                                    16'd16384, 32'h00640000, 32'h00320000));
            send_sprite(make_sprite(16'd32, 16'd16, 32'h00100000, 32'h00080000,
                                    16'h0100, 16'h0100, 16'd32768, 32'h0, 32'h0));
            send_sprite(make_sprite(16'd32, 16'd16, 32'h0, 32'h0, 16'h0100, 16'h0100,
                                    16'd49152, 32'h0, 32'h0));
            send_sprite(make_sprite(16'd10, 16'd10, 32'h0, 32'h0, 16'h0200, 16'h0080,
                                    16'd8191, 32'h0, 32'h0));
            send_sprite(make_sprite(16'd10, 16'd10, 32'h0, 32'h0, 16'h0200, 16'h0080,
                                    16'd8192, 32'h0, 32'h0));
            send_sprite(make_sprite(16'd10, 16'd10, 32'h0, 32'h0, 16'h0100, 16'h0100,
                                    16'd65535, 32'h0, 32'h0));
            send_sprite(make_sprite(16'd0, 16'd0, 32'h00050000, 32'h00050000,
                                    16'h0100, 16'h0100, 16'd1000, 32'h0, 32'h0));
            send_sprite(make_sprite(16'd0, 16'd20, 32'h0, 32'h0, 16'h0100, 16'h0100,
                                    16'd0, 32'h0, 32'h0));
            send_sprite(make_sprite(16'd20, 16'd0, 32'h0, 32'h0, 16'h0100, 16'h0100,
                                    16'd0, 32'h0, 32'h0));
            send_sprite(make_sprite(16'd40, 16'd40, 32'h0, 32'h0, 16'h0000, 16'h0000,
                                    16'd5000, 32'h00010000, 32'h00020000));
            send_sprite(make_sprite(16'd40, 16'd40, 32'h0, 32'h0, 16'hFF00, 16'h0100,
                                    16'd0, 32'h0, 32'h0));
            send_sprite(make_sprite(16'd40, 16'd40, 32'h0, 32'h0, 16'h8000, 16'h8000,
                                    16'd12345, 32'h0, 32'h0));
            send_sprite(make_sprite(16'hFFFF, 16'hFFFF, 32'h0, 32'h0, 16'h7FFF, 16'h7FFF,
                                    16'd0, 32'h7FFFFFFF, 32'h7FFFFFFF));
            send_sprite(make_sprite(16'hFFFF, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                    16'h7FFF, 16'h7FFF, 16'd32768, 32'h80000000,
                                    32'h80000000));
            send_sprite(make_sprite(16'hFFFF, 16'hFFFF, 32'h80000000, 32'h80000000,
                                    16'h8000, 16'h7FFF, 16'd20000, 32'h0, 32'h0));
            send_sprite(make_sprite(16'hFFFF, 16'h0001, 32'hFFFFFFFF, 32'h00000001,
                                    16'h0001, 16'hFFFF, 16'd40000, 32'hFFFFFFFF,
                                    32'h00000001));
            send_sprite(make_sprite(16'd1, 16'd1, 32'h00008000, 32'h00008000, 16'h0100,
                                    16'h0100, 16'd24576, 32'h0, 32'h0));
        end
    endtask

    // Ordinary sprites: modest sizes and scales, any angle, and positions of up to 0x10000000 in magnitude.
    task automatic test_typical(int count);
        begin
            for (int n = 0; n < count; n++)
            begin
                idle_mode = (n / 40) % 2 == 0 ? 1 : 0;
                send_sprite(make_sprite(16'($urandom_range(0, 512)),
                                        16'($urandom_range(0, 512)),
                                        32'($signed($urandom_range(0, 32'h02000000)) -
                                            32'sh01000000),
                                        32'($signed($urandom_range(0, 32'h02000000)) -
                                            32'sh01000000),
                                        16'($signed($urandom_range(0, 16'h0800)) -
                                            16'sh0400),
                                        16'($signed($urandom_range(0, 16'h0800)) -
                                            16'sh0400),
                                        16'($urandom),
                                        32'($signed($urandom_range(0, 32'h20000000)) -
                                            32'sh10000000),
                                        32'($signed($urandom_range(0, 32'h20000000)) -
                                            32'sh10000000)));
            end
        end
    endtask

    // Every field at random over its full width; many corners saturate.
    task automatic test_full_range(int count);
        begin
            idle_mode = 1;
            for (int n = 0; n < count; n++)
                send_sprite(make_sprite(16'($urandom), 16'($urandom), $urandom, $urandom,
                                        16'($urandom), 16'($urandom), 16'($urandom),
                                        $urandom, $urandom));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_typical(320);
        test_full_range(120);
        in_valid <= 1'b0;
        while (expected_corners.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 30) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sprite_corner_transform_top.f @@
sv/sct_pkg.sv
sv/sct_cordic.sv
sv/sprite_corner_transform_top.sv
tb/tb_top.sv
